// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker module of the voltage guard.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define RWVG_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define RWVG_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== rtl/rwvg_pkg.sv =====
// Types, constants and the microcode table of the RMS window voltage guard.
`timescale 1ns / 1ps

package rwvg_pkg;

   // Field and datapath widths.
   localparam int OFFSET_W  = 12;
   localparam int GAIN_W    = 20;
   localparam int LIMIT_W   = 14;
   localparam int LEN_W     = 10;
   localparam int SUM_W     = 33;
   localparam int SUM_EXT_W = SUM_W + 1;
   localparam int ROOT_W    = 17;
   localparam int PROD_W    = ROOT_W + GAIN_W;
   localparam int Q_FRAC    = 16;
   localparam int RMS_W     = 14;
   localparam int STATUS_W  = 2;
   localparam int CNT_W     = 6;
   localparam int STEP_W    = 4;

   localparam logic [RMS_W-1:0] RMS_MAX = '1;

   // Result word packing.
   localparam int RSP_BITS    = RMS_W + STATUS_W + 1;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;

   // Status codes.
   localparam logic [STATUS_W-1:0] STATUS_NORMAL = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OVER   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNDER  = 2'd2;

   // Register file map.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = GAIN_W;
   localparam logic [CSR_ADDR_W-1:0] REG_OFFSET     = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_GAIN       = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_HIGH_LIMIT = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_LOW_LIMIT  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_WINDOW_LEN = 3'd4;

   // Register reset values.
   localparam logic [OFFSET_W-1:0] OFFSET_RESET = 12'd2048;
   localparam logic [GAIN_W-1:0]   GAIN_RESET   = 20'd287750;
   localparam logic [LIMIT_W-1:0]  HIGH_RESET   = 14'd8000;
   localparam logic [LIMIT_W-1:0]  LOW_RESET    = 14'd3000;
   localparam logic [LEN_W-1:0]    LEN_RESET    = 10'd100;

   typedef struct packed {
      logic [OFFSET_W-1:0] offset_code;
      logic [GAIN_W-1:0]   gain_q16;
      logic [LIMIT_W-1:0]  high_limit;
      logic [LIMIT_W-1:0]  low_limit;
      logic [LEN_W-1:0]    window_len;
   } cfg_type;

   typedef struct packed {
      logic                protect;
      logic [STATUS_W-1:0] status;
      logic [RMS_W-1:0]    rms;
   } result_type;

   // Datapath operations, one per control word.
   typedef enum logic [3:0] {
      OP_NOP       = 4'd0,
      OP_TAKE      = 4'd1,
      OP_SQUARE    = 4'd2,
      OP_ACCUM     = 4'd3,
      OP_DIV_INIT  = 4'd4,
      OP_DIV_STEP  = 4'd5,
      OP_ROOT_INIT = 4'd6,
      OP_ROOT_STEP = 4'd7,
      OP_SCALE     = 4'd8,
      OP_JUDGE     = 4'd9,
      OP_EMIT      = 4'd10
   } op_type;

   // Jump conditions: when true the sequencer goes to the target step.
   typedef enum logic [2:0] {
      CND_NEXT     = 3'd0,
      CND_GOTO     = 3'd1,
      CND_NO_INPUT = 3'd2,
      CND_OPEN     = 3'd3,
      CND_LOOP     = 3'd4,
      CND_OUT_BUSY = 3'd5
   } cond_type;

   typedef logic [STEP_W-1:0] step_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ucode_type;

   // Conditions seen by the sequencer.
   typedef struct packed {
      logic in_fire;
      logic window_open;
      logic out_busy;
   } seq_status_type;

   // Program steps.
   localparam step_type ST_IDLE   = 4'd0;
   localparam step_type ST_SQUARE = 4'd1;
   localparam step_type ST_ACCUM  = 4'd2;
   localparam step_type ST_DINIT  = 4'd3;
   localparam step_type ST_DIV    = 4'd4;
   localparam step_type ST_RINIT  = 4'd5;
   localparam step_type ST_ROOT   = 4'd6;
   localparam step_type ST_SCALE  = 4'd7;
   localparam step_type ST_JUDGE  = 4'd8;
   localparam step_type ST_WAIT   = 4'd9;
   localparam step_type ST_EMIT   = 4'd10;

   // The control program.
   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type word;
      case (step)
         ST_IDLE:   word = '{op: OP_TAKE,      cond: CND_NO_INPUT, target: ST_IDLE};
         ST_SQUARE: word = '{op: OP_SQUARE,    cond: CND_NEXT,     target: ST_IDLE};
         ST_ACCUM:  word = '{op: OP_ACCUM,     cond: CND_OPEN,     target: ST_IDLE};
         ST_DINIT:  word = '{op: OP_DIV_INIT,  cond: CND_NEXT,     target: ST_IDLE};
         ST_DIV:    word = '{op: OP_DIV_STEP,  cond: CND_LOOP,     target: ST_DIV};
         ST_RINIT:  word = '{op: OP_ROOT_INIT, cond: CND_NEXT,     target: ST_IDLE};
         ST_ROOT:   word = '{op: OP_ROOT_STEP, cond: CND_LOOP,     target: ST_ROOT};
         ST_SCALE:  word = '{op: OP_SCALE,     cond: CND_NEXT,     target: ST_IDLE};
         ST_JUDGE:  word = '{op: OP_JUDGE,     cond: CND_NEXT,     target: ST_IDLE};
         ST_WAIT:   word = '{op: OP_NOP,       cond: CND_OUT_BUSY, target: ST_WAIT};
         ST_EMIT:   word = '{op: OP_EMIT,      cond: CND_GOTO,     target: ST_IDLE};
         default:   word = '{op: OP_NOP,       cond: CND_GOTO,     target: ST_IDLE};
      endcase
      return word;
   endfunction

endpackage

// ===== rtl/rwvg_sequencer.sv =====
// Step counter, control store and loop counter of the voltage guard.
`timescale 1ns / 1ps

module rwvg_sequencer (
   input  logic                     clock,
   input  logic                     reset,
   input  rwvg_pkg::seq_status_type status,
   output rwvg_pkg::ucode_type      ucode
);

   rwvg_pkg::step_type          step_ff, step_in;
   logic [rwvg_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic                        jump;

   // Fetch the control word of the current step.
   assign ucode = rwvg_pkg::ucode_rom(step_ff);

   // Evaluate the jump condition.
   always_comb begin
      case (ucode.cond)
         rwvg_pkg::CND_NEXT:     jump = 1'b0;
         rwvg_pkg::CND_GOTO:     jump = 1'b1;
         rwvg_pkg::CND_NO_INPUT: jump = !status.in_fire;
         rwvg_pkg::CND_OPEN:     jump = status.window_open;
         rwvg_pkg::CND_LOOP:     jump = (cnt_ff != rwvg_pkg::CNT_W'(1));
         rwvg_pkg::CND_OUT_BUSY: jump = status.out_busy;
         default:                jump = 1'b0;
      endcase
   end

   assign step_in = jump ? ucode.target : step_ff + rwvg_pkg::STEP_W'(1);

   // The loop counter is loaded by the init steps and counts iterations down.
   always_comb begin
      case (ucode.op)
         rwvg_pkg::OP_DIV_INIT:  cnt_in = rwvg_pkg::CNT_W'(rwvg_pkg::SUM_W);
         rwvg_pkg::OP_ROOT_INIT: cnt_in = rwvg_pkg::CNT_W'(rwvg_pkg::ROOT_W);
         rwvg_pkg::OP_DIV_STEP,
         rwvg_pkg::OP_ROOT_STEP: cnt_in = cnt_ff - rwvg_pkg::CNT_W'(1);
         default:                cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= rwvg_pkg::ST_IDLE;
         cnt_ff  <= '0;
      end else begin
         step_ff <= step_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

// ===== rtl/rwvg_datapath.sv =====
// Square-and-sum, serial divider, serial square root, gain scaling and limit tests.
`timescale 1ns / 1ps

module rwvg_datapath #(
   parameter int SAMPLE_BITS = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rwvg_pkg::ucode_type    ucode,
   input  logic                   in_fire,
   input  logic [SAMPLE_BITS-1:0] sample,
   input  rwvg_pkg::cfg_type      cfg,
   output logic                   window_open,
   output rwvg_pkg::result_type   result
);

   localparam int SQ_W  = 2 * SAMPLE_BITS;
   localparam int EXT_W = SAMPLE_BITS + rwvg_pkg::OFFSET_W;
   localparam int RMS_FULL_W = rwvg_pkg::PROD_W - rwvg_pkg::Q_FRAC;

   // Window state.
   logic [rwvg_pkg::SUM_W-1:0]     sum_ff, sum_in;
   logic [rwvg_pkg::LEN_W-1:0]     count_ff, count_in;
   rwvg_pkg::result_type           result_ff, result_in;

   // Work registers.
   logic [SAMPLE_BITS-1:0]         sample_ff, sample_in;
   logic [SQ_W-1:0]                sq_ff, sq_in;
   logic [rwvg_pkg::LEN_W-1:0]     divisor_ff, divisor_in;
   logic [rwvg_pkg::SUM_W-1:0]     acc_ff, acc_in;
   logic [rwvg_pkg::LEN_W-1:0]     rem_ff, rem_in;
   logic [rwvg_pkg::SUM_EXT_W-1:0] root_ff, root_in;
   logic [rwvg_pkg::SUM_W-1:0]     bit_ff, bit_in;
   logic [rwvg_pkg::PROD_W-1:0]    prod_ff, prod_in;

   // Intermediate values.
   logic [EXT_W-1:0]               off_ext;
   logic [SAMPLE_BITS-1:0]         off;
   logic [SAMPLE_BITS-1:0]         mag;
   logic [rwvg_pkg::SUM_EXT_W-1:0] sum_wide;
   logic [rwvg_pkg::SUM_W-1:0]     sum_sat;
   logic [rwvg_pkg::LEN_W:0]       taken;
   logic [rwvg_pkg::LEN_W-1:0]     len_eff;
   logic [rwvg_pkg::LEN_W:0]       shifted;
   logic [rwvg_pkg::LEN_W:0]       div_diff;
   logic                           div_ge;
   logic [rwvg_pkg::SUM_EXT_W-1:0] trial;
   logic                           root_ge;
   logic [RMS_FULL_W-1:0]          rms_full;
   logic [rwvg_pkg::RMS_W-1:0]     rms_sat;

   assign result = result_ff;

   // Absolute difference from the bias point, offset cut to the sample width.
   assign off_ext = {{SAMPLE_BITS{1'b0}}, cfg.offset_code};
   assign off     = off_ext[SAMPLE_BITS-1:0];
   assign mag     = (sample_ff >= off) ? (sample_ff - off) : (off - sample_ff);

   // Saturating sum of squares.
   assign sum_wide = {1'b0, sum_ff} + rwvg_pkg::SUM_EXT_W'(sq_ff);
   assign sum_sat  = sum_wide[rwvg_pkg::SUM_W] ? '1 : sum_wide[rwvg_pkg::SUM_W-1:0];

   // Window close test; a zero length behaves as one.
   assign taken       = {1'b0, count_ff} + (rwvg_pkg::LEN_W + 1)'(1);
   assign len_eff     = (cfg.window_len == '0) ? rwvg_pkg::LEN_W'(1) : cfg.window_len;
   assign window_open = (taken < {1'b0, len_eff});

   // One restoring division step: quotient bits shift into acc_ff from the right.
   assign shifted  = {rem_ff, acc_ff[rwvg_pkg::SUM_W-1]};
   assign div_ge   = (shifted >= {1'b0, divisor_ff});
   assign div_diff = shifted - {1'b0, divisor_ff};

   // One square root step on the remainder held in acc_ff.
   assign trial   = root_ff + {1'b0, bit_ff};
   assign root_ge = ({1'b0, acc_ff} >= trial);

   // Drop the Q16 fraction and saturate.
   assign rms_full = prod_ff[rwvg_pkg::PROD_W-1:rwvg_pkg::Q_FRAC];
   assign rms_sat  = (rms_full > RMS_FULL_W'(rwvg_pkg::RMS_MAX)) ?
                     rwvg_pkg::RMS_MAX : rms_full[rwvg_pkg::RMS_W-1:0];

   // Next values under the current control word.
   always_comb begin
      sample_in  = sample_ff;
      sq_in      = sq_ff;
      sum_in     = sum_ff;
      count_in   = count_ff;
      divisor_in = divisor_ff;
      acc_in     = acc_ff;
      rem_in     = rem_ff;
      root_in    = root_ff;
      bit_in     = bit_ff;
      prod_in    = prod_ff;
      result_in  = result_ff;
      case (ucode.op)
         rwvg_pkg::OP_TAKE: begin
            if (in_fire) begin
               sample_in = sample;
            end
         end
         rwvg_pkg::OP_SQUARE: begin
            sq_in = mag * mag;
         end
         rwvg_pkg::OP_ACCUM: begin
            sum_in     = sum_sat;
            divisor_in = taken[rwvg_pkg::LEN_W-1:0];
            if (window_open) begin
               count_in = taken[rwvg_pkg::LEN_W-1:0];
            end
         end
         rwvg_pkg::OP_DIV_INIT: begin
            acc_in = sum_ff;
            rem_in = '0;
         end
         rwvg_pkg::OP_DIV_STEP: begin
            rem_in = div_ge ? div_diff[rwvg_pkg::LEN_W-1:0] : shifted[rwvg_pkg::LEN_W-1:0];
            acc_in = {acc_ff[rwvg_pkg::SUM_W-2:0], div_ge};
         end
         rwvg_pkg::OP_ROOT_INIT: begin
            root_in = '0;
            bit_in  = {1'b1, {(rwvg_pkg::SUM_W - 1){1'b0}}};
         end
         rwvg_pkg::OP_ROOT_STEP: begin
            if (root_ge) begin
               acc_in  = acc_ff - trial[rwvg_pkg::SUM_W-1:0];
               root_in = (root_ff >> 1) + {1'b0, bit_ff};
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
         end
         rwvg_pkg::OP_SCALE: begin
            prod_in = root_ff[rwvg_pkg::ROOT_W-1:0] * cfg.gain_q16;
         end
         rwvg_pkg::OP_JUDGE: begin
            result_in.rms = rms_sat;
            if (rms_sat > cfg.high_limit) begin
               result_in.status  = rwvg_pkg::STATUS_OVER;
               result_in.protect = 1'b1;
            end else if (rms_sat < cfg.low_limit) begin
               result_in.status  = rwvg_pkg::STATUS_UNDER;
               result_in.protect = 1'b1;
            end else begin
               result_in.status  = rwvg_pkg::STATUS_NORMAL;
               result_in.protect = 1'b0;
            end
            sum_in   = '0;
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   // Window state and protection flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff    <= '0;
         count_ff  <= '0;
         result_ff <= '0;
      end else begin
         sum_ff    <= sum_in;
         count_ff  <= count_in;
         result_ff <= result_in;
      end
   end

   // Work registers.
   always_ff @(posedge clock) begin
      sample_ff  <= sample_in;
      sq_ff      <= sq_in;
      divisor_ff <= divisor_in;
      acc_ff     <= acc_in;
      rem_ff     <= rem_in;
      root_ff    <= root_in;
      bit_ff     <= bit_in;
      prod_ff    <= prod_in;
   end

endmodule

// ===== rtl/rms_window_voltage_guard_unit.sv =====
// Top level of the RMS window voltage guard: registers, output stage, sequencer, datapath.
//
//   Channel  Direction  Ports                       Word contents
//   req      in         req_tvalid/tready/tdata     sample
//   rsp      out        rsp_tvalid/tready/tdata     rms_centivolts, status, protect
//   csr      in         csr_we/addr/wdata           offset, gain, high, low, window length
//
// A sample that leaves its window open passes through the accept, square and accumulate steps.
// A sample that closes the window then runs the divider, which retires one quotient bit
// per cycle, and the square root, which retires one result bit per cycle, plus
// setup, scaling, limit test and output load.
// Reset is synchronous and active high; it loads the register defaults and clears the window.
// While a result waits in the output register new samples are still taken; only the output
// load step waits for that register to empty.
`timescale 1ns / 1ps

module rms_window_voltage_guard_unit #(
   parameter int SAMPLE_BITS = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   // Sample words.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] req_tdata,  // [SAMPLE_BITS-1:0] sample
   // Result words.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [rwvg_pkg::RSP_TDATA_W-1:0]    rsp_tdata,  // [13:0] rms_centivolts,
                                                           // [15:14] status, [16] protect
   // Register writes.
   input  logic                                csr_we,
   input  logic [rwvg_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [rwvg_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   rwvg_pkg::cfg_type        cfg_ff, cfg_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rwvg_pkg::result_type     rsp_data_ff, rsp_data_in;
   rwvg_pkg::ucode_type      ucode;
   rwvg_pkg::seq_status_type seq_status;
   rwvg_pkg::result_type     result;
   logic                     window_open;
   logic                     in_fire;

   // Input handshake: taken only in the idle step.
   assign req_tready = (ucode.op == rwvg_pkg::OP_TAKE);
   assign in_fire    = req_tvalid && req_tready;

   assign seq_status.in_fire     = in_fire;
   assign seq_status.window_open = window_open;
   assign seq_status.out_busy    = rsp_valid_ff && !rsp_tready;

   // Register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            rwvg_pkg::REG_OFFSET:     cfg_in.offset_code = csr_wdata[rwvg_pkg::OFFSET_W-1:0];
            rwvg_pkg::REG_GAIN:       cfg_in.gain_q16    = csr_wdata[rwvg_pkg::GAIN_W-1:0];
            rwvg_pkg::REG_HIGH_LIMIT: cfg_in.high_limit  = csr_wdata[rwvg_pkg::LIMIT_W-1:0];
            rwvg_pkg::REG_LOW_LIMIT:  cfg_in.low_limit   = csr_wdata[rwvg_pkg::LIMIT_W-1:0];
            rwvg_pkg::REG_WINDOW_LEN: cfg_in.window_len  = csr_wdata[rwvg_pkg::LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Output register: loaded by the emit step, emptied by the sink.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (ucode.op == rwvg_pkg::OP_EMIT) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.offset_code <= rwvg_pkg::OFFSET_RESET;
         cfg_ff.gain_q16    <= rwvg_pkg::GAIN_RESET;
         cfg_ff.high_limit  <= rwvg_pkg::HIGH_RESET;
         cfg_ff.low_limit   <= rwvg_pkg::LOW_RESET;
         cfg_ff.window_len  <= rwvg_pkg::LEN_RESET;
         rsp_valid_ff       <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rwvg_pkg::RSP_TDATA_W'(rsp_data_ff);

   // Control sequencer.
   rwvg_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .status (seq_status),
      .ucode  (ucode)
   );

   // Arithmetic datapath.
   rwvg_datapath #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .ucode       (ucode),
      .in_fire     (in_fire),
      .sample      (req_tdata[SAMPLE_BITS-1:0]),
      .cfg         (cfg_ff),
      .window_open (window_open),
      .result      (result)
   );

endmodule

// ===== rtl/rwvg_checker.sv =====
// Port-level checks on the result channel of the voltage guard, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rwvg_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [rwvg_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   logic rsp_flagged;

   // The status field reports an over or under voltage.
   assign rsp_flagged = (rsp_tdata[15:14] != rwvg_pkg::STATUS_NORMAL);

   // A stalled word stays offered.
   `RWVG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)

   // A stalled word keeps its contents.
   `RWVG_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))

   // Protection is on exactly when the status is not normal.
   `RWVG_ASSERT_IMPL(a_protect_status, clock, reset, rsp_tvalid, rsp_tdata[16] == rsp_flagged)

   // Results are at least a window apart, so two never follow back to back.
   `RWVG_ASSERT_NEXT(a_rsp_gap, clock, reset, rsp_tvalid && rsp_tready, !rsp_tvalid)

endmodule

bind rms_window_voltage_guard_unit rwvg_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== bench/tb_top.sv =====
// Self-checking testbench for the RMS window voltage guard unit.
`timescale 1ns / 1ps

module tb_top;

   localparam int SAMPLE_W      = 12;
   localparam int REQ_TDATA_W   = ((SAMPLE_W + 7) / 8) * 8;
   localparam int SETTLE_CYCLES = 80;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int RANDOM_PHASES = 16;
   localparam int PHASE_SAMPLES = 80;
   localparam int SAT_SAMPLES   = 540;
   localparam int SAMPLE_TOP    = (1 << SAMPLE_W) - 1;
   localparam longint unsigned SUM_CAP = (64'd1 << rwvg_pkg::SUM_W) - 64'd1;

   // An index that maps to no register; writes to it must change nothing.
   localparam logic [rwvg_pkg::CSR_ADDR_W-1:0] REG_UNMAPPED = 3'd7;

   // Pacing modes for the two stream sides.
   localparam int PACE_NONE   = 0;
   localparam int PACE_SENDER = 1;
   localparam int PACE_STALL  = 2;
   localparam int PACE_BOTH   = 3;

   // Tracks the window state of the guard and holds the results it owes.
   class guard_scoreboard;
      rwvg_pkg::cfg_type               regs;
      logic [rwvg_pkg::SUM_W-1:0]      square_sum;
      logic [rwvg_pkg::LEN_W-1:0]      sample_count;
      logic                            protect_flag;
      rwvg_pkg::result_type            owed_results[$];
      int                              mismatches;
      int                              windows_seen;
      int                              samples_seen;

      function new();
         regs = '{offset_code: rwvg_pkg::OFFSET_RESET, gain_q16: rwvg_pkg::GAIN_RESET,
                  high_limit: rwvg_pkg::HIGH_RESET, low_limit: rwvg_pkg::LOW_RESET,
                  window_len: rwvg_pkg::LEN_RESET};
         square_sum   = '0;
         sample_count = '0;
         protect_flag = 1'b0;
         mismatches   = 0;
         windows_seen = 0;
         samples_seen = 0;
      endfunction

      function void set_reg(logic [rwvg_pkg::CSR_ADDR_W-1:0] idx,
                            logic [rwvg_pkg::CSR_DATA_W-1:0] value);
         case (idx)
            rwvg_pkg::REG_OFFSET:     regs.offset_code = value[rwvg_pkg::OFFSET_W-1:0];
            rwvg_pkg::REG_GAIN:       regs.gain_q16    = value[rwvg_pkg::GAIN_W-1:0];
            rwvg_pkg::REG_HIGH_LIMIT: regs.high_limit  = value[rwvg_pkg::LIMIT_W-1:0];
            rwvg_pkg::REG_LOW_LIMIT:  regs.low_limit   = value[rwvg_pkg::LIMIT_W-1:0];
            rwvg_pkg::REG_WINDOW_LEN: regs.window_len  = value[rwvg_pkg::LEN_W-1:0];
            default: ;
         endcase
      endfunction

      // Largest root whose square does not exceed the argument, found bit by bit.
      function logic [rwvg_pkg::ROOT_W-1:0] floor_root(longint unsigned v);
         logic [rwvg_pkg::ROOT_W-1:0] r;
         longint unsigned             trial;
         r = '0;
         for (int b = rwvg_pkg::ROOT_W - 1; b >= 0; b--) begin
            trial = r | (64'd1 << b);
            if (trial * trial <= v) r = rwvg_pkg::ROOT_W'(trial);
         end
         return r;
      endfunction

      // Folds one accepted sample into the window; a closing sample owes a result.
      function void take_sample(logic [SAMPLE_W-1:0] s);
         longint unsigned               mag;
         longint unsigned               acc;
         longint unsigned               mean;
         longint unsigned               scaled;
         int unsigned                   taken;
         int unsigned                   span;
         logic [rwvg_pkg::ROOT_W-1:0]   root;
         logic [rwvg_pkg::STATUS_W-1:0] verdict;
         samples_seen++;
         mag = (s >= regs.offset_code) ? s - regs.offset_code : regs.offset_code - s;
         acc = square_sum + mag * mag;
         if (acc > SUM_CAP) acc = SUM_CAP;
         taken = sample_count + 1;
         span  = (regs.window_len == 0) ? 1 : regs.window_len;
         if (taken < span) begin
            square_sum   = rwvg_pkg::SUM_W'(acc);
            sample_count = rwvg_pkg::LEN_W'(taken);
            return;
         end
         // The window closes: mean square, root, gain, then the limit tests.
         mean   = acc / taken;
         root   = floor_root(mean);
         scaled = root;
         scaled = (scaled * regs.gain_q16) >> rwvg_pkg::Q_FRAC;
         if (scaled > rwvg_pkg::RMS_MAX) scaled = rwvg_pkg::RMS_MAX;
         if (scaled > regs.high_limit) begin
            verdict      = rwvg_pkg::STATUS_OVER;
            protect_flag = 1'b1;
         end else if (scaled < regs.low_limit) begin
            verdict      = rwvg_pkg::STATUS_UNDER;
            protect_flag = 1'b1;
         end else begin
            verdict      = rwvg_pkg::STATUS_NORMAL;
            protect_flag = 1'b0;
         end
         owed_results.push_back('{protect: protect_flag, status: verdict,
                                  rms: rwvg_pkg::RMS_W'(scaled)});
         square_sum   = '0;
         sample_count = '0;
      endfunction

      // Compares one result word with the oldest owed result.
      function void check_word(logic [rwvg_pkg::RSP_TDATA_W-1:0] word);
         rwvg_pkg::result_type got;
         rwvg_pkg::result_type want;
         got = word[rwvg_pkg::RSP_BITS-1:0];
         if (owed_results.size() == 0) begin
            $error("result word %h arrived with no window closed", word);
            mismatches++;
            return;
         end
         want = owed_results.pop_front();
         windows_seen++;
         if (got.rms !== want.rms) begin
            $error("rms_centivolts: expected %0d, actual %0d", want.rms, got.rms);
            mismatches++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            mismatches++;
         end
         if (got.protect !== want.protect) begin
            $error("protect: expected %0d, actual %0d", want.protect, got.protect);
            mismatches++;
         end
         if (word[rwvg_pkg::RSP_TDATA_W-1:rwvg_pkg::RSP_BITS] !== '0) begin
            $error("padding: expected 0, actual %0h",
                   word[rwvg_pkg::RSP_TDATA_W-1:rwvg_pkg::RSP_BITS]);
            mismatches++;
         end
      endfunction
   endclass

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [REQ_TDATA_W-1:0]              req_tdata = '0;   // [11:0] sample
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [rwvg_pkg::RSP_TDATA_W-1:0]    rsp_tdata;        // [13:0] rms_centivolts,
                                                          // [15:14] status, [16] protect
   logic                                csr_we = 1'b0;
   logic [rwvg_pkg::CSR_ADDR_W-1:0]     csr_addr = '0;
   logic [rwvg_pkg::CSR_DATA_W-1:0]     csr_wdata = '0;

   guard_scoreboard board = new();
   int send_idle_pct  = 0;
   int rsp_stall_pct  = 0;
   int settings_written = 0;
   int cycles = 0;

   rms_window_voltage_guard_unit #(.SAMPLE_BITS(SAMPLE_W)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("rms_window_voltage_guard_unit verification failed");
         $finish;
      end
   end

   // Result side: check each word taken, then decide whether to stall next cycle.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_word(rsp_tdata);
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Offers one sample word, optionally after an idle gap, and waits for it to be taken.
   task automatic send_sample(input logic [SAMPLE_W-1:0] s);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_TDATA_W'(s);
      do @(posedge clock); while (!req_tready);
      board.take_sample(s);
   endtask

   // Writes one register; the guard must be idle.
   task automatic write_reg(input logic [rwvg_pkg::CSR_ADDR_W-1:0] idx,
                            input logic [rwvg_pkg::CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      board.set_reg(idx, value);
      csr_we <= 1'b0;
      @(posedge clock);
      settings_written++;
   endtask

   // Waits for every owed result, then lets a window computation run out.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (board.owed_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_pacing(input int mode);
      case (mode)
         PACE_SENDER: begin send_idle_pct = 59; rsp_stall_pct = 0;  end
         PACE_STALL:  begin send_idle_pct = 0;  rsp_stall_pct = 59; end
         PACE_BOTH:   begin send_idle_pct = 32; rsp_stall_pct = 32; end
         default:     begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
      endcase
   endtask

   // Register value with random bits above the register's width.
   function automatic logic [rwvg_pkg::CSR_DATA_W-1:0] with_noise(int unsigned value,
                                                                  int width);
      return rwvg_pkg::CSR_DATA_W'(value) | (rwvg_pkg::CSR_DATA_W'($urandom) << width);
   endfunction

   initial begin
      int offset;
      int high;
      int low;
      int amp;
      int pick;
      int unsigned span;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: one-sample windows at the reset scaling, around both limits.
      set_pacing(PACE_NONE);
      write_reg(rwvg_pkg::REG_WINDOW_LEN, 20'd1);
      send_sample(12'h000);
      send_sample(12'hFFF);
      send_sample(12'd2048);
      send_sample(12'd3048);
      send_sample(12'd3870);
      send_sample(12'd3871);
      send_sample(12'd2731);
      send_sample(12'd2732);
      settle();

      // A zero window length behaves as one sample per window.
      write_reg(rwvg_pkg::REG_WINDOW_LEN, 20'd0);
      send_sample(12'h555);
      send_sample(12'hAAA);
      settle();

      // Crossed limits: the high test is made first.
      write_reg(rwvg_pkg::REG_HIGH_LIMIT, 20'd100);
      write_reg(rwvg_pkg::REG_LOW_LIMIT, 20'd16383);
      send_sample(12'd2048);
      send_sample(12'd2100);
      send_sample(12'd2060);
      settle();

      // Full gain saturates the RMS; zero gain gives zero.
      write_reg(rwvg_pkg::REG_OFFSET, 20'd0);
      write_reg(rwvg_pkg::REG_GAIN, 20'hFFFFF);
      write_reg(rwvg_pkg::REG_HIGH_LIMIT, 20'd16383);
      write_reg(rwvg_pkg::REG_LOW_LIMIT, 20'd0);
      send_sample(12'hFFF);
      send_sample(12'h000);
      settle();
      write_reg(rwvg_pkg::REG_GAIN, 20'd0);
      send_sample(12'd1234);
      settle();

      // Shortening the window with samples already taken closes it on the next one.
      write_reg(rwvg_pkg::REG_OFFSET, rwvg_pkg::CSR_DATA_W'(rwvg_pkg::OFFSET_RESET));
      write_reg(rwvg_pkg::REG_GAIN, rwvg_pkg::CSR_DATA_W'(rwvg_pkg::GAIN_RESET));
      write_reg(rwvg_pkg::REG_HIGH_LIMIT, rwvg_pkg::CSR_DATA_W'(rwvg_pkg::HIGH_RESET));
      write_reg(rwvg_pkg::REG_LOW_LIMIT, rwvg_pkg::CSR_DATA_W'(rwvg_pkg::LOW_RESET));
      write_reg(rwvg_pkg::REG_WINDOW_LEN, 20'd4);
      send_sample(12'd100);
      send_sample(12'd4000);
      send_sample(12'd2500);
      settle();
      write_reg(rwvg_pkg::REG_WINDOW_LEN, 20'd2);
      send_sample(12'd1800);
      settle();

      // Longest window with words a full scale away from the offset drives the sum into saturation,
      // then a shortened length closes it.
      set_pacing(PACE_BOTH);
      write_reg(rwvg_pkg::REG_OFFSET, 20'd4095);
      write_reg(rwvg_pkg::REG_WINDOW_LEN, 20'd1023);
      write_reg(REG_UNMAPPED, 20'd5);
      for (int n = 0; n < SAT_SAMPLES; n++) send_sample(SAMPLE_W'($urandom_range(5)));
      settle();
      write_reg(rwvg_pkg::REG_WINDOW_LEN, 20'd1);
      send_sample(12'd0);
      settle();

      // Random phases: new settings and pacing each time, mostly short windows.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         set_pacing(p % 4);
         pick = $urandom_range(7);
         offset = (pick == 0) ? 0 : (pick == 1) ? SAMPLE_TOP : $urandom_range(1500, 2600);
         high = $urandom_range(2000, 14000);
         low  = ($urandom_range(9) == 0) ? $urandom_range(high, 16383)
                                         : $urandom_range(0, high);
         if (p == 5) span = 0;
         else if ($urandom_range(3) == 0) span = $urandom_range(9, 40);
         else span = $urandom_range(1, 8);
         amp = $urandom_range(0, 2047);
         write_reg(rwvg_pkg::REG_OFFSET, with_noise(offset, rwvg_pkg::OFFSET_W));
         write_reg(rwvg_pkg::REG_GAIN,
                   rwvg_pkg::CSR_DATA_W'(($urandom_range(3) == 0) ?
                                         $urandom_range(0, 1048575) :
                                         $urandom_range(150000, 450000)));
         write_reg(rwvg_pkg::REG_HIGH_LIMIT, with_noise(high, rwvg_pkg::LIMIT_W));
         write_reg(rwvg_pkg::REG_LOW_LIMIT, with_noise(low, rwvg_pkg::LIMIT_W));
         write_reg(rwvg_pkg::REG_WINDOW_LEN, with_noise(span, rwvg_pkg::LEN_W));
         write_reg(REG_UNMAPPED, rwvg_pkg::CSR_DATA_W'($urandom));
         for (int n = 0; n < PHASE_SAMPLES; n++) begin
            if ($urandom_range(1) == 0) begin
               send_sample(SAMPLE_W'($urandom_range(SAMPLE_TOP)));
            end else begin
               pick = offset + $urandom_range(2 * amp) - amp;
               if (pick < 0) pick = 0;
               if (pick > SAMPLE_TOP) pick = SAMPLE_TOP;
               send_sample(SAMPLE_W'(pick));
            end
         end
         settle();
      end

      // Wrap up.
      if (board.owed_results.size() != 0) begin
         $error("%0d window results never arrived", board.owed_results.size());
         board.mismatches++;
      end
      $display("Ran %0d samples into %0d checked window results over %0d register writes.",
               board.samples_seen, board.windows_seen, settings_written);
      $display("Included saturated sums, a shortened window, crossed limits and mixed pacing.");
      if (board.mismatches == 0) begin
         $display("rms_window_voltage_guard_unit verification clean");
      end else begin
         $display("rms_window_voltage_guard_unit verification failed");
      end
      $finish;
   end

endmodule
